### sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted linked table
// Pool size, field widths, operation and status codes, link reset pattern.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 31;
  localparam int HND_W   = 16;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [HND_W-1:0] hnd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    idx_t data;
  } link_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    key_t key;
    hnd_t hnd;
  } rec_wr_t;

  typedef struct packed {
    idx_t link;
    key_t key;
    hnd_t hnd;
  } rd_data_t;

  // link of an entry never written since reset: next entry, last wraps to 0
  function automatic idx_t reset_link(idx_t i);
    idx_t r;
    if (i == idx_t'(ENTRIES - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

endpackage

### sv/slt_in_if.sv
// ----------------------------------------------------------------------------
// slt_in_if: request channel of the sorted linked table
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface slt_in_if;
  logic                      valid;
  logic                      ready;
  logic [slt_pkg::MODE_W-1:0] mode;
  slt_pkg::key_t             key;
  slt_pkg::hnd_t             record_handle;

  modport source (output valid, output mode, output key, output record_handle, input ready);
  modport sink   (input valid, input mode, input key, input record_handle, output ready);
endinterface

// ----------------------------------------------------------------------------
// slt_out_if: result channel of the sorted linked table
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface slt_out_if;
  logic                        valid;
  logic                        ready;
  logic [slt_pkg::STAT_W-1:0]  status;
  slt_pkg::hnd_t               found_handle;
  logic [slt_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output found_handle, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_handle, input entry_count,
                  output ready);
endinterface

### sv/sorted_linked_table.sv
// ----------------------------------------------------------------------------
// sorted_linked_table: sorted circular linked list over a fixed entry pool
// Insert, delete by key and search by key over a list kept in ascending key
// order, with unused entries chained on a free list.
//
//   channel   dir   beat fields                            accepted when
//   in_bus    in    mode, key, record_handle               valid && ready
//   out_bus   out   status, found_handle, entry_count      valid && ready
//
// one operation at a time; ready only while the sequencer is idle
// search/delete: walk from head in S_WALK, then S_WR1 and S_WR2 on a delete hit, then S_DONE
// insert: S_FETCHQ takes the free entry, S_WALK (skipped when empty), S_WR1, S_WR2, S_DONE
// walk speed is one link per cycle, set by the single store read port
// a waiting result holds the next operation in its done cycle; reset needs no sweep
// ----------------------------------------------------------------------------
module sorted_linked_table (
  input  logic     clk,
  input  logic     rst_n,
  slt_in_if.sink   in_bus,
  slt_out_if.source out_bus
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCHQ = 6'b000010,
    S_WALK   = 6'b000100,
    S_WR1    = 6'b001000,
    S_WR2    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  slt_pkg::mode_t      mode_r, mode_nxt;
  slt_pkg::key_t       key_r, key_nxt;
  slt_pkg::hnd_t       hnd_r, hnd_nxt;
  slt_pkg::idx_t       head_r, head_nxt;
  slt_pkg::idx_t       tail_r, tail_nxt;
  slt_pkg::idx_t       free_r, free_nxt;
  slt_pkg::cnt_t       used_r, used_nxt;
  slt_pkg::idx_t       cur_r, cur_nxt;
  slt_pkg::idx_t       prev_r, prev_nxt;
  slt_pkg::cnt_t       i_r, i_nxt;
  slt_pkg::idx_t       q_r, q_nxt;
  slt_pkg::idx_t       wa1_r, wa1_nxt, wd1_r, wd1_nxt;
  slt_pkg::idx_t       wa2_r, wa2_nxt, wd2_r, wd2_nxt;
  slt_pkg::status_t    stat_r, stat_nxt;
  slt_pkg::hnd_t       found_r, found_nxt;

  logic                        out_valid_r;
  logic [slt_pkg::STAT_W-1:0]  out_stat_r;
  slt_pkg::hnd_t               out_found_r;
  logic [slt_pkg::COUNT_W-1:0] out_cnt_r;
  logic                        out_load;

  slt_pkg::idx_t     rd_addr;
  slt_pkg::link_wr_t link_wr;
  slt_pkg::rec_wr_t  rec_wr;
  slt_pkg::rd_data_t rd;
  logic              in_beat;

  slt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .link_wr (link_wr),
    .rec_wr  (rec_wr),
    .rd_data (rd)
  );

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_beat      = in_bus.valid && in_bus.ready;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    hnd_nxt   = hnd_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    used_nxt  = used_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    i_nxt     = i_r;
    q_nxt     = q_r;
    wa1_nxt   = wa1_r;
    wd1_nxt   = wd1_r;
    wa2_nxt   = wa2_r;
    wd2_nxt   = wd2_r;
    stat_nxt  = stat_r;
    found_nxt = found_r;
    rd_addr   = cur_r;
    out_load  = 1'b0;
    link_wr   = '{en: 1'b0, addr: wa1_r, data: wd1_r};
    rec_wr    = '{en: 1'b0, addr: q_r, key: key_r, hnd: hnd_r};

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          mode_nxt  = slt_pkg::mode_t'(in_bus.mode);
          key_nxt   = in_bus.key;
          hnd_nxt   = in_bus.record_handle;
          cur_nxt   = head_r;
          prev_nxt  = tail_r;
          i_nxt     = '0;
          found_nxt = '0;
          stat_nxt  = slt_pkg::STAT_OK;
          case (slt_pkg::mode_t'(in_bus.mode))
            slt_pkg::MODE_INSERT: begin
              if (used_r == slt_pkg::cnt_t'(slt_pkg::ENTRIES)) begin
                stat_nxt  = slt_pkg::STAT_FULL;
                state_nxt = S_DONE;
              end else begin
                q_nxt     = free_r;
                rd_addr   = free_r;
                state_nxt = S_FETCHQ;
              end
            end
            slt_pkg::MODE_DELETE, slt_pkg::MODE_SEARCH: begin
              rd_addr   = head_r;
              state_nxt = S_WALK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FETCHQ: begin
        // rd holds the free link of the taken entry
        free_nxt = rd.link;
        rd_addr  = head_r;
        if (used_r == '0) begin
          wa1_nxt   = q_r;
          wd1_nxt   = q_r;
          wa2_nxt   = q_r;
          wd2_nxt   = q_r;
          head_nxt  = q_r;
          tail_nxt  = q_r;
          used_nxt  = used_r + slt_pkg::cnt_t'(1);
          state_nxt = S_WR1;
        end else begin
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        // rd holds the entry at cur_r
        if (i_r == used_r) begin
          if (mode_r == slt_pkg::MODE_INSERT) begin
            // append after tail
            wa1_nxt   = tail_r;
            wd1_nxt   = q_r;
            wa2_nxt   = q_r;
            wd2_nxt   = head_r;
            tail_nxt  = q_r;
            used_nxt  = used_r + slt_pkg::cnt_t'(1);
            state_nxt = S_WR1;
          end else begin
            stat_nxt  = slt_pkg::STAT_MISS;
            state_nxt = S_DONE;
          end
        end else if (mode_r == slt_pkg::MODE_INSERT) begin
          if (rd.key < key_r) begin
            prev_nxt = cur_r;
            cur_nxt  = rd.link;
            i_nxt    = i_r + slt_pkg::cnt_t'(1);
            rd_addr  = rd.link;
          end else begin
            if (i_r == '0) begin
              wa1_nxt  = q_r;
              wd1_nxt  = head_r;
              wa2_nxt  = tail_r;
              wd2_nxt  = q_r;
              head_nxt = q_r;
            end else begin
              wa1_nxt = prev_r;
              wd1_nxt = q_r;
              wa2_nxt = q_r;
              wd2_nxt = cur_r;
            end
            used_nxt  = used_r + slt_pkg::cnt_t'(1);
            state_nxt = S_WR1;
          end
        end else if (rd.key == key_r) begin
          if (mode_r == slt_pkg::MODE_SEARCH) begin
            found_nxt = rd.hnd;
            state_nxt = S_DONE;
          end else begin
            // unlink cur_r, then push it on the free list
            if (used_r == slt_pkg::cnt_t'(1)) begin
              wa1_nxt = cur_r;
              wd1_nxt = free_r;
            end else if (cur_r == head_r) begin
              head_nxt = rd.link;
              wa1_nxt  = tail_r;
              wd1_nxt  = rd.link;
            end else if (cur_r == tail_r) begin
              tail_nxt = prev_r;
              wa1_nxt  = prev_r;
              wd1_nxt  = head_r;
            end else begin
              wa1_nxt = prev_r;
              wd1_nxt = rd.link;
            end
            wa2_nxt   = cur_r;
            wd2_nxt   = free_r;
            free_nxt  = cur_r;
            used_nxt  = used_r - slt_pkg::cnt_t'(1);
            state_nxt = S_WR1;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = rd.link;
          i_nxt    = i_r + slt_pkg::cnt_t'(1);
          rd_addr  = rd.link;
        end
      end

      S_WR1: begin
        link_wr   = '{en: 1'b1, addr: wa1_r, data: wd1_r};
        rec_wr.en = (mode_r == slt_pkg::MODE_INSERT);
        state_nxt = S_WR2;
      end

      S_WR2: begin
        link_wr   = '{en: 1'b1, addr: wa2_r, data: wd2_r};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      used_r  <= used_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    key_r   <= key_nxt;
    hnd_r   <= hnd_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    i_r     <= i_nxt;
    q_r     <= q_nxt;
    wa1_r   <= wa1_nxt;
    wd1_r   <= wd1_nxt;
    wa2_r   <= wa2_nxt;
    wd2_r   <= wd2_nxt;
    stat_r  <= stat_nxt;
    found_r <= found_nxt;
    if (out_load) begin
      out_stat_r  <= stat_r;
      out_found_r <= found_r;
      out_cnt_r   <= slt_pkg::COUNT_W'(used_r);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_stat_r;
  assign out_bus.found_handle = out_found_r;
  assign out_bus.entry_count  = out_cnt_r;

  // count stays within the pool
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= slt_pkg::cnt_t'(slt_pkg::ENTRIES))
    else $error("entry count beyond pool size");

  // walk index never passes the list length
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (i_r <= used_r))
    else $error("walk ran past list length");

  // pool full is only reported with a full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status == slt_pkg::STAT_FULL) |->
      (out_bus.entry_count == slt_pkg::COUNT_W'(slt_pkg::ENTRIES)))
    else $error("pool full beat without full count");

endmodule

### sv/slt_store.sv
// ----------------------------------------------------------------------------
// slt_store: entry storage of the sorted linked table
// Link, key and handle memories, one shared registered read port. Links carry
// per-entry valid bits so unwritten links read as the reset chain.
// ----------------------------------------------------------------------------
module slt_store (
  input  logic              clk,
  input  logic              rst_n,
  input  slt_pkg::idx_t     rd_addr,
  input  slt_pkg::link_wr_t link_wr,
  input  slt_pkg::rec_wr_t  rec_wr,
  output slt_pkg::rd_data_t rd_data
);

  slt_pkg::idx_t             link_mem [slt_pkg::ENTRIES];
  slt_pkg::key_t             key_mem  [slt_pkg::ENTRIES];
  slt_pkg::hnd_t             hnd_mem  [slt_pkg::ENTRIES];
  logic [slt_pkg::ENTRIES-1:0] link_vld_r;
  slt_pkg::rd_data_t         rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (link_wr.en) begin
      link_vld_r[link_wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (link_wr.en) begin
      link_mem[link_wr.addr] <= link_wr.data;
    end
    if (rec_wr.en) begin
      key_mem[rec_wr.addr] <= rec_wr.key;
      hnd_mem[rec_wr.addr] <= rec_wr.hnd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r.link <= link_vld_r[rd_addr] ? link_mem[rd_addr] : slt_pkg::reset_link(rd_addr);
    rd_data_r.key  <= key_mem[rd_addr];
    rd_data_r.hnd  <= hnd_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
